FILE: hw/rtl/wbg_pkg.sv
`default_nettype none
package wbg_pkg;

   localparam int MAX_WAYPOINTS = 16;
   localparam int CORDIC_STEPS  = 16;
   localparam int GUARD_BITS    = 8;

   localparam int SLOT_W  = $clog2(MAX_WAYPOINTS);
   localparam int STEP_W  = $clog2(CORDIC_STEPS);
   localparam int POS_W   = 24;
   localparam int DIFF_W  = POS_W + 1;
   localparam int CORD_W  = DIFF_W + GUARD_BITS + 3;
   localparam int ANG_W   = 16;
   localparam int TURN_W  = 32;
   localparam int DIST_W  = 25;
   localparam int COUNT_W = 5;
   localparam int RADIUS_W = 23;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 23;

   localparam int GAIN_W  = 28;
   localparam int MAG_W   = CORD_W - 1;
   localparam int MAG_LO_W = (MAG_W + 1) / 2;
   localparam int MAG_HI_W = MAG_W - MAG_LO_W;
   localparam int PROD_W  = MAG_LO_W + GAIN_W;
   localparam int SUM_W   = MAG_W + GAIN_W + 1;
   localparam int FRAC_SHIFT = GAIN_W + GUARD_BITS;

   localparam logic [GAIN_W-1:0] INV_GAIN = 28'd163008219;
   localparam logic [TURN_W-1:0] QUARTER_TURN = 32'h4000_0000;
   localparam logic [TURN_W-1:0] ANG_ROUND = 32'h0000_8000;

   localparam int ATAN_DEPTH = 24;
   localparam int ATAN_IDX_W = $clog2(ATAN_DEPTH);
   localparam logic [TURN_W-1:0] ATAN_TURNS [ATAN_DEPTH] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_POSE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_WAYPOINT_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ARRIVE_RADIUS  = 1'b1;

   localparam logic [COUNT_W-1:0]  COUNT_RESET  = 5'd1;
   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 23'd1024;

   typedef struct packed {
      logic              load_wr;
      logic              pose_start;
      logic              diff;
      logic              pre;
      logic              iter;
      logic [STEP_W-1:0] step;
      logic              mul_lo;
      logic              mul_hi;
      logic              fin;
      logic              out_load;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } sts_type;

endpackage
`default_nettype wire

FILE: hw/rtl/wbg_ctrl.sv
`default_nettype none
module wbg_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic             req_command,
   input  wire wbg_pkg::sts_type sts,
   output wbg_pkg::cmd_type      cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DIFF   = 3'd1;
   localparam logic [2:0] S_PRE    = 3'd2;
   localparam logic [2:0] S_ITER   = 3'd3;
   localparam logic [2:0] S_MUL_LO = 3'd4;
   localparam logic [2:0] S_MUL_HI = 3'd5;
   localparam logic [2:0] S_FIN    = 3'd6;
   localparam logic [2:0] S_OUT    = 3'd7;

   localparam logic [wbg_pkg::STEP_W-1:0] LAST_STEP =
      wbg_pkg::STEP_W'(wbg_pkg::CORDIC_STEPS - 1);

   logic [2:0]                   state_ff, state_in;
   logic [wbg_pkg::STEP_W-1:0]   step_ff, step_in;

   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      cmd       = '0;
      cmd.step  = step_ff;
      req_ready = (state_ff == S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_command == wbg_pkg::CMD_POSE) begin
                  cmd.pose_start = 1'b1;
                  state_in       = S_DIFF;
               end else begin
                  cmd.load_wr = 1'b1;
               end
            end
         end
         S_DIFF: begin
            cmd.diff = 1'b1;
            state_in = S_PRE;
         end
         S_PRE: begin
            cmd.pre  = 1'b1;
            step_in  = '0;
            state_in = S_ITER;
         end
         S_ITER: begin
            cmd.iter = 1'b1;
            if (step_ff == LAST_STEP) begin
               state_in = S_MUL_LO;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_MUL_LO: begin
            cmd.mul_lo = 1'b1;
            state_in   = S_MUL_HI;
         end
         S_MUL_HI: begin
            cmd.mul_hi = 1'b1;
            state_in   = S_FIN;
         end
         S_FIN: begin
            cmd.fin  = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule
`default_nettype wire

FILE: hw/rtl/wbg_datapath.sv
`default_nettype none
module wbg_datapath (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire wbg_pkg::cmd_type                       cmd,
   output wbg_pkg::sts_type                            sts,
   input  wire logic signed [wbg_pkg::POS_W-1:0]       req_pos_x,
   input  wire logic signed [wbg_pkg::POS_W-1:0]       req_pos_y,
   input  wire logic signed [wbg_pkg::ANG_W-1:0]       req_heading,
   input  wire logic        [wbg_pkg::SLOT_W-1:0]      req_wp_slot,
   input  wire logic signed [wbg_pkg::POS_W-1:0]       req_wp_x,
   input  wire logic signed [wbg_pkg::POS_W-1:0]       req_wp_y,
   input  wire logic        [wbg_pkg::COUNT_W-1:0]     waypoint_count,
   input  wire logic        [wbg_pkg::RADIUS_W-1:0]    arrive_radius,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic signed      [wbg_pkg::POS_W-1:0]       rsp_target_x,
   output logic signed      [wbg_pkg::POS_W-1:0]       rsp_target_y,
   output logic signed      [wbg_pkg::ANG_W-1:0]       rsp_bearing,
   output logic signed      [wbg_pkg::ANG_W-1:0]       rsp_heading_error,
   output logic             [wbg_pkg::DIST_W-1:0]      rsp_distance,
   output logic             [3:0]                      rsp_waypoint_number,
   output logic                                        rsp_advanced
);

   localparam int POS_W  = wbg_pkg::POS_W;
   localparam int DIFF_W = wbg_pkg::DIFF_W;
   localparam int CORD_W = wbg_pkg::CORD_W;
   localparam int ANG_W  = wbg_pkg::ANG_W;
   localparam int TURN_W = wbg_pkg::TURN_W;
   localparam int SLOT_W = wbg_pkg::SLOT_W;
   localparam int LO_W   = wbg_pkg::MAG_LO_W;
   localparam int HI_W   = wbg_pkg::MAG_HI_W;
   localparam int PROD_W = wbg_pkg::PROD_W;
   localparam int SUM_W  = wbg_pkg::SUM_W;
   localparam int DIST_W = wbg_pkg::DIST_W;
   localparam int CNT_W  = wbg_pkg::COUNT_W;
   localparam int RND_W  = SUM_W - wbg_pkg::FRAC_SHIFT;

   // waypoint store, x in the upper half
   logic [2*POS_W-1:0] wp_store_ff [wbg_pkg::MAX_WAYPOINTS];

   logic signed [POS_W-1:0]  target_x_ff, target_y_ff;
   logic signed [POS_W-1:0]  pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic        [ANG_W-1:0]  heading_ff, heading_in;
   logic        [SLOT_W-1:0] idx_ff, idx_in, cur_idx_ff, cur_idx_in;
   logic signed [DIFF_W-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic                     zero_ff, zero_in;
   logic signed [CORD_W-1:0] re_ff, re_in, im_ff, im_in;
   logic        [TURN_W-1:0] z_ff, z_in;
   logic        [PROD_W-1:0] plo_ff, plo_in, phi_ff, phi_in;
   logic        [DIST_W-1:0] dist_ff, dist_in;
   logic        [ANG_W-1:0]  bearing_ff, bearing_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [POS_W-1:0]  rsp_tx_ff, rsp_tx_in, rsp_ty_ff, rsp_ty_in;
   logic        [ANG_W-1:0]  rsp_brg_ff, rsp_brg_in, rsp_herr_ff, rsp_herr_in;
   logic        [DIST_W-1:0] rsp_dist_ff, rsp_dist_in;
   logic        [SLOT_W-1:0] rsp_num_ff, rsp_num_in;
   logic                     rsp_adv_ff, rsp_adv_in;

   logic signed [CORD_W-1:0] re0, im0, rs, is;
   logic        [TURN_W-1:0] atan_val;
   logic        [LO_W-1:0]   mul_a;
   logic        [PROD_W-1:0] mul_p;
   logic        [SUM_W-1:0]  sum;
   logic        [RND_W-1:0]  rnd;
   logic                     adv;
   logic        [CNT_W-1:0]  cnt, inc;
   logic        [SLOT_W-1:0] next_idx;

   function automatic logic [ANG_W-1:0] z_in_round(input logic [TURN_W-1:0] z);
      logic [TURN_W-1:0] t;
      t = z + wbg_pkg::ANG_ROUND;
      return t[TURN_W-1:TURN_W-ANG_W];
   endfunction

   always_ff @(posedge clock) begin
      if (cmd.load_wr) begin
         wp_store_ff[req_wp_slot] <= {req_wp_x, req_wp_y};
      end
      if (cmd.pose_start) begin
         {target_x_ff, target_y_ff} <= wp_store_ff[cur_idx_ff];
      end
   end

   always_comb begin
      re0 = {{(CORD_W - DIFF_W - wbg_pkg::GUARD_BITS){dy_ff[DIFF_W-1]}}, dy_ff,
             {wbg_pkg::GUARD_BITS{1'b0}}};
      im0 = {{(CORD_W - DIFF_W - wbg_pkg::GUARD_BITS){dx_ff[DIFF_W-1]}}, dx_ff,
             {wbg_pkg::GUARD_BITS{1'b0}}};
      rs  = re_ff >>> cmd.step;
      is  = im_ff >>> cmd.step;
      atan_val = wbg_pkg::ATAN_TURNS[wbg_pkg::ATAN_IDX_W'(cmd.step)];

      mul_a = cmd.mul_hi ? LO_W'(re_ff[LO_W+HI_W-1:LO_W]) : re_ff[LO_W-1:0];
      mul_p = PROD_W'(mul_a) * PROD_W'(wbg_pkg::INV_GAIN);

      sum = SUM_W'(plo_ff) + {phi_ff[SUM_W-LO_W-1:0], {LO_W{1'b0}}}
            + (SUM_W'(1) << (wbg_pkg::FRAC_SHIFT - 1));
      rnd = sum[SUM_W-1:wbg_pkg::FRAC_SHIFT];

      if (waypoint_count == '0) begin
         cnt = CNT_W'(1);
      end else if (waypoint_count > CNT_W'(wbg_pkg::MAX_WAYPOINTS)) begin
         cnt = CNT_W'(wbg_pkg::MAX_WAYPOINTS);
      end else begin
         cnt = waypoint_count;
      end
      inc      = CNT_W'(idx_ff) + CNT_W'(1);
      next_idx = (inc >= cnt) ? '0 : SLOT_W'(inc);
      adv      = dist_ff < DIST_W'(arrive_radius);

      pos_x_in   = cmd.pose_start ? req_pos_x : pos_x_ff;
      pos_y_in   = cmd.pose_start ? req_pos_y : pos_y_ff;
      heading_in = cmd.pose_start ? req_heading : heading_ff;
      idx_in     = cmd.pose_start ? cur_idx_ff : idx_ff;

      dx_in   = dx_ff;
      dy_in   = dy_ff;
      zero_in = zero_ff;
      if (cmd.diff) begin
         dx_in   = DIFF_W'(target_x_ff) - DIFF_W'(pos_x_ff);
         dy_in   = DIFF_W'(target_y_ff) - DIFF_W'(pos_y_ff);
         zero_in = (target_x_ff == pos_x_ff) && (target_y_ff == pos_y_ff);
      end

      re_in = re_ff;
      im_in = im_ff;
      z_in  = z_ff;
      if (cmd.pre) begin
         // fold the left half plane onto the right
         if (!re0[CORD_W-1]) begin
            re_in = re0;
            im_in = im0;
            z_in  = '0;
         end else if (!im0[CORD_W-1]) begin
            re_in = im0;
            im_in = -re0;
            z_in  = wbg_pkg::QUARTER_TURN;
         end else begin
            re_in = -im0;
            im_in = re0;
            z_in  = -wbg_pkg::QUARTER_TURN;
         end
      end else if (cmd.iter) begin
         if (!im_ff[CORD_W-1]) begin
            re_in = re_ff + is;
            im_in = im_ff - rs;
            z_in  = z_ff + atan_val;
         end else begin
            re_in = re_ff - is;
            im_in = im_ff + rs;
            z_in  = z_ff - atan_val;
         end
      end

      plo_in = cmd.mul_lo ? mul_p : plo_ff;
      phi_in = cmd.mul_hi ? mul_p : phi_ff;

      dist_in    = dist_ff;
      bearing_in = bearing_ff;
      if (cmd.fin) begin
         if (zero_ff) begin
            dist_in    = '0;
            bearing_in = '0;
         end else begin
            dist_in    = (|rnd[RND_W-1:DIST_W]) ? '1 : rnd[DIST_W-1:0];
            bearing_in = z_in_round(z_ff);
         end
      end

      cur_idx_in  = (cmd.out_load && adv) ? next_idx : cur_idx_ff;
      rsp_tx_in   = cmd.out_load ? target_x_ff : rsp_tx_ff;
      rsp_ty_in   = cmd.out_load ? target_y_ff : rsp_ty_ff;
      rsp_brg_in  = cmd.out_load ? bearing_ff : rsp_brg_ff;
      rsp_herr_in = cmd.out_load ? (bearing_ff - heading_ff) : rsp_herr_ff;
      rsp_dist_in = cmd.out_load ? dist_ff : rsp_dist_ff;
      rsp_num_in  = cmd.out_load ? idx_ff : rsp_num_ff;
      rsp_adv_in  = cmd.out_load ? adv : rsp_adv_ff;
      rsp_valid_in = cmd.out_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      pos_x_ff    <= pos_x_in;
      pos_y_ff    <= pos_y_in;
      heading_ff  <= heading_in;
      idx_ff      <= idx_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      zero_ff     <= zero_in;
      re_ff       <= re_in;
      im_ff       <= im_in;
      z_ff        <= z_in;
      plo_ff      <= plo_in;
      phi_ff      <= phi_in;
      dist_ff     <= dist_in;
      bearing_ff  <= bearing_in;
      rsp_tx_ff   <= rsp_tx_in;
      rsp_ty_ff   <= rsp_ty_in;
      rsp_brg_ff  <= rsp_brg_in;
      rsp_herr_ff <= rsp_herr_in;
      rsp_dist_ff <= rsp_dist_in;
      rsp_num_ff  <= rsp_num_in;
      rsp_adv_ff  <= rsp_adv_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_idx_ff   <= cur_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign sts.out_free        = !rsp_valid_ff || rsp_ready;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_target_x        = rsp_tx_ff;
   assign rsp_target_y        = rsp_ty_ff;
   assign rsp_bearing         = rsp_brg_ff;
   assign rsp_heading_error   = rsp_herr_ff;
   assign rsp_distance        = rsp_dist_ff;
   assign rsp_waypoint_number = 4'(rsp_num_ff);
   assign rsp_advanced        = rsp_adv_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/waypoint_bearing_guidance.sv
// Waypoint guidance: a request with command 0 loads one waypoint into a 16-slot store and
// gives no response; a request with command 1 is a pose and gives one response with the
// current target, the bearing atan2(dx, dy) from the y axis, the wrapped heading error and
// the distance, and moves on to the next waypoint when the distance is below arrive_radius.
// A pose passes through the difference, the fold, 16 iterations of the one CORDIC unit, a
// low and a high multiply for gain removal, rounding and output; req_ready is high only
// between poses, and the output register lets the next request enter while a response
// waits. Slots read before they are written return undefined data.
`default_nettype none
module waypoint_bearing_guidance (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic                                   req_command,
   input  wire logic signed [23:0]                     req_pos_x,
   input  wire logic signed [23:0]                     req_pos_y,
   input  wire logic signed [15:0]                     req_heading,
   input  wire logic        [3:0]                      req_wp_slot,
   input  wire logic signed [23:0]                     req_wp_x,
   input  wire logic signed [23:0]                     req_wp_y,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic signed      [23:0]                     rsp_target_x,
   output logic signed      [23:0]                     rsp_target_y,
   output logic signed      [15:0]                     rsp_bearing,
   output logic signed      [15:0]                     rsp_heading_error,
   output logic             [24:0]                     rsp_distance,
   output logic             [3:0]                      rsp_waypoint_number,
   output logic                                        rsp_advanced,
   input  wire logic                                   csr_write_enable,
   input  wire logic        [wbg_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic        [wbg_pkg::CSR_DATA_W-1:0]  csr_write_data
);

   logic [wbg_pkg::COUNT_W-1:0]  waypoint_count_ff, waypoint_count_in;
   logic [wbg_pkg::RADIUS_W-1:0] arrive_radius_ff, arrive_radius_in;

   wbg_pkg::cmd_type cmd;
   wbg_pkg::sts_type sts;

   always_comb begin
      waypoint_count_in = waypoint_count_ff;
      arrive_radius_in  = arrive_radius_ff;
      if (csr_write_enable) begin
         case (csr_index)
            wbg_pkg::CSR_WAYPOINT_COUNT: begin
               waypoint_count_in = csr_write_data[wbg_pkg::COUNT_W-1:0];
            end
            wbg_pkg::CSR_ARRIVE_RADIUS: begin
               arrive_radius_in = csr_write_data[wbg_pkg::RADIUS_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         waypoint_count_ff <= wbg_pkg::COUNT_RESET;
         arrive_radius_ff  <= wbg_pkg::RADIUS_RESET;
      end else begin
         waypoint_count_ff <= waypoint_count_in;
         arrive_radius_ff  <= arrive_radius_in;
      end
   end

   wbg_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .sts         (sts),
      .cmd         (cmd)
   );

   wbg_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_pos_x           (req_pos_x),
      .req_pos_y           (req_pos_y),
      .req_heading         (req_heading),
      .req_wp_slot         (req_wp_slot),
      .req_wp_x            (req_wp_x),
      .req_wp_y            (req_wp_y),
      .waypoint_count      (waypoint_count_ff),
      .arrive_radius       (arrive_radius_ff),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_target_x        (rsp_target_x),
      .rsp_target_y        (rsp_target_y),
      .rsp_bearing         (rsp_bearing),
      .rsp_heading_error   (rsp_heading_error),
      .rsp_distance        (rsp_distance),
      .rsp_waypoint_number (rsp_waypoint_number),
      .rsp_advanced        (rsp_advanced)
   );

endmodule
`default_nettype wire

FILE: tb/guidance_checker.sv
module guidance_checker import wbg_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   req_ready,
   input  wire logic                   req_command,
   input  wire logic signed [23:0]     req_pos_x,
   input  wire logic signed [23:0]     req_pos_y,
   input  wire logic signed [15:0]     req_heading,
   input  wire logic        [3:0]      req_wp_slot,
   input  wire logic signed [23:0]     req_wp_x,
   input  wire logic signed [23:0]     req_wp_y,
   input  wire logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   input  wire logic signed [23:0]     rsp_target_x,
   input  wire logic signed [23:0]     rsp_target_y,
   input  wire logic signed [15:0]     rsp_bearing,
   input  wire logic signed [15:0]     rsp_heading_error,
   input  wire logic        [24:0]     rsp_distance,
   input  wire logic        [3:0]      rsp_waypoint_number,
   input  wire logic                   rsp_advanced,
   input  wire logic                   csr_write_enable,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_write_data,
   output int                          failures,
   output int                          outstanding,
   output logic [3:0]                  aim_slot,
   output int                          checked,
   output int                          advances
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [31:0] ARCTAN_TURN [16] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861
   };
   localparam logic [63:0] GAIN_RECIPROCAL = 64'd163008219;
   localparam logic [63:0] DIST_MAX        = 64'h1FF_FFFF;

   typedef struct {
      logic signed [23:0] target_x;
      logic signed [23:0] target_y;
      logic signed [15:0] bearing;
      logic signed [15:0] heading_error;
      logic        [24:0] distance;
      logic        [3:0]  waypoint_number;
      logic               advanced;
   } guidance_type;

   logic signed [23:0] route_x [16];
   logic signed [23:0] route_y [16];
   logic [3:0]         current_wp;
   logic [4:0]         waypoint_count;
   logic [22:0]        arrive_radius;
   guidance_type       expected_q [$];

   task automatic report_failure(input string msg);
      if (failures < 100) begin
         $display("ERROR: %s", msg);
      end
      failures++;
   endtask

   task automatic compare_field(input string name, input logic signed [63:0] got,
                                input logic signed [63:0] want);
      if (got !== want) begin
         report_failure($sformatf("response %0d: %s is %0d, expected %0d",
                                  checked, name, got, want));
      end
   endtask

   // vectoring rotation: angle in 32-bit turns, magnitude scaled by the gain
   task automatic vector_rotate(input longint re_in, input longint im_in,
                                output logic [31:0] turn, output longint mag);
      longint re, im, swap, re_sh, im_sh;
      re = re_in;
      im = im_in;
      turn = '0;
      if (re < 0) begin
         if (im >= 0) begin
            swap = re; re = im; im = -swap; turn = QUARTER_TURN;
         end else begin
            swap = re; re = -im; im = swap; turn = 32'd0 - QUARTER_TURN;
         end
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         re_sh = re >>> i;
         im_sh = im >>> i;
         if (im >= 0) begin
            re += im_sh; im -= re_sh; turn += ARCTAN_TURN[i];
         end else begin
            re -= im_sh; im += re_sh; turn -= ARCTAN_TURN[i];
         end
      end
      mag = re;
   endtask

   task automatic predict_guidance(input logic signed [23:0] px, input logic signed [23:0] py,
                                   input logic [15:0] hd, output guidance_type g);
      longint dx, dy, mag;
      logic [31:0] turn, rounded;
      logic [63:0] span;
      logic [15:0] brg;
      logic [4:0]  used;
      g.target_x = route_x[current_wp];
      g.target_y = route_y[current_wp];
      g.waypoint_number = current_wp;
      dx = longint'(route_x[current_wp]) - longint'(px);
      dy = longint'(route_y[current_wp]) - longint'(py);
      if (dx == 0 && dy == 0) begin
         brg = '0;
         span = '0;
      end else begin
         vector_rotate(dy * 256, dx * 256, turn, mag);
         rounded = turn + ANG_ROUND;
         brg = rounded[31:16];
         span = (64'(mag) * GAIN_RECIPROCAL + (64'd1 << 35)) >> 36;
         if (span > DIST_MAX) span = DIST_MAX;
      end
      g.bearing = brg;
      g.heading_error = brg - hd;
      g.distance = span[24:0];
      g.advanced = (span < 64'(arrive_radius));
      if (g.advanced) begin
         used = waypoint_count;
         if (used == 5'd0) used = 5'd1;
         if (used > 5'(MAX_WAYPOINTS)) used = 5'(MAX_WAYPOINTS);
         current_wp = (5'(current_wp) + 5'd1 >= used) ? 4'd0 : current_wp + 4'd1;
      end
   endtask

   always @(posedge clock) begin
      guidance_type want;
      guidance_type got;
      if (reset) begin
         foreach (route_x[i]) begin
            route_x[i] = '0;
            route_y[i] = '0;
         end
         current_wp = '0;
         waypoint_count = COUNT_RESET;
         arrive_radius = RADIUS_RESET;
         expected_q.delete();
         failures = 0;
         checked = 0;
         advances = 0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_WAYPOINT_COUNT: waypoint_count = csr_write_data[COUNT_W-1:0];
               CSR_ARRIVE_RADIUS:  arrive_radius = csr_write_data[RADIUS_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               report_failure($sformatf("response for waypoint %0d with no pose pending",
                                        rsp_waypoint_number));
            end else begin
               want = expected_q.pop_front();
               compare_field("target_x", rsp_target_x, want.target_x);
               compare_field("target_y", rsp_target_y, want.target_y);
               compare_field("bearing", rsp_bearing, want.bearing);
               compare_field("heading_error", rsp_heading_error, want.heading_error);
               compare_field("distance", rsp_distance, want.distance);
               compare_field("waypoint_number", rsp_waypoint_number, want.waypoint_number);
               compare_field("advanced", rsp_advanced, want.advanced);
               if (want.advanced) advances++;
               checked++;
            end
         end
         if (req_valid && req_ready) begin
            if (req_command == CMD_LOAD) begin
               route_x[req_wp_slot] = req_wp_x;
               route_y[req_wp_slot] = req_wp_y;
            end else begin
               predict_guidance(req_pos_x, req_pos_y, req_heading, got);
               expected_q.push_back(got);
            end
         end
      end
      outstanding = expected_q.size();
      aim_slot = current_wp;
   end

endmodule

FILE: tb/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import wbg_pkg::*;

   localparam int PHASES       = 9;
   localparam int PHASE_ITEMS  = 142;
   localparam int DRAIN_CYCLES = 40;
   localparam int HOLD_CYCLES  = 300;
   localparam logic signed [23:0] POS_MAX = 24'sh7FFFFF;
   localparam logic signed [23:0] POS_MIN = -24'sh800000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic                        req_command = CMD_LOAD;
   logic signed [23:0]          req_pos_x = '0;
   logic signed [23:0]          req_pos_y = '0;
   logic signed [15:0]          req_heading = '0;
   logic        [3:0]           req_wp_slot = '0;
   logic signed [23:0]          req_wp_x = '0;
   logic signed [23:0]          req_wp_y = '0;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic signed [23:0]          rsp_target_x;
   logic signed [23:0]          rsp_target_y;
   logic signed [15:0]          rsp_bearing;
   logic signed [15:0]          rsp_heading_error;
   logic        [24:0]          rsp_distance;
   logic        [3:0]           rsp_waypoint_number;
   logic                        rsp_advanced;
   logic                        csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0]        csr_index = '0;
   logic [CSR_DATA_W-1:0]       csr_write_data = '0;

   int         failures;
   int         outstanding;
   logic [3:0] aim_slot;
   int         checked;
   int         advances;

   int send_idle_pct = 15;
   int recv_idle_pct = 71;
   int holds_asked = 0;
   int holds_served = 0;
   int hold_left = 0;
   int spread_now = 1024;
   int loads_sent = 0;
   int poses_sent = 0;
   int settings_used = 0;

   logic signed [23:0] loaded_x [16];
   logic signed [23:0] loaded_y [16];

   int phase_count  [PHASES] = '{1, 16, 3, 0, 31, 16, 2, 5, 16};
   int phase_radius [PHASES] = '{1024, 8388607, 4096, 0, 30000, 600, 8388607, 12000, 2000};

   waypoint_bearing_guidance u_dut (.*);

   guidance_checker u_checker (.*);

   always #1 clock = ~clock;

   initial begin
      #2_000_000;
      $display("timeout: block stopped making progress");
      $display("Simulation FAILED");
      $finish;
   end

   // response side: random back-pressure plus requested long hold-offs
   initial begin
      forever begin
         @(negedge clock);
         if (hold_left == 0 && holds_served != holds_asked) begin
            holds_served++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   function automatic logic signed [23:0] near(input logic signed [23:0] centre,
                                               input int spread);
      longint v;
      v = longint'(centre) + longint'($urandom_range(2 * spread)) - spread;
      if (v > longint'(POS_MAX)) v = POS_MAX;
      if (v < longint'(POS_MIN)) v = POS_MIN;
      return v[23:0];
   endfunction

   task automatic send_request(input logic cmd, input logic signed [23:0] px,
                               input logic signed [23:0] py, input logic [15:0] hd,
                               input logic [3:0] slot, input logic signed [23:0] wx,
                               input logic signed [23:0] wy);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_pos_x <= px;
      req_pos_y <= py;
      req_heading <= hd;
      req_wp_slot <= slot;
      req_wp_x <= wx;
      req_wp_y <= wy;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      if (cmd == CMD_LOAD) begin
         loaded_x[slot] = wx;
         loaded_y[slot] = wy;
         loads_sent++;
      end else begin
         poses_sent++;
      end
   endtask

   task automatic send_pose(input logic signed [23:0] px, input logic signed [23:0] py,
                            input logic [15:0] hd);
      send_request(CMD_POSE, px, py, hd, 4'($urandom()), 24'($urandom()), 24'($urandom()));
   endtask

   task automatic send_load(input logic [3:0] slot, input logic signed [23:0] wx,
                            input logic signed [23:0] wy);
      send_request(CMD_LOAD, 24'($urandom()), 24'($urandom()), 16'($urandom()), slot, wx, wy);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_mode(input int count, input int radius);
      wait_idle();
      csr_write_enable <= 1'b1;
      csr_index <= CSR_WAYPOINT_COUNT;
      csr_write_data <= CSR_DATA_W'(count);
      @(negedge clock);
      csr_index <= CSR_ARRIVE_RADIUS;
      csr_write_data <= CSR_DATA_W'(radius);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      spread_now = (radius < 64) ? 64 : ((radius > (1 << 20)) ? (1 << 20) : radius);
      settings_used++;
   endtask

   task automatic random_item();
      int pick;
      logic [3:0] slot;
      pick = $urandom_range(99);
      slot = aim_slot;
      if (pick < 20) begin
         send_load(4'($urandom_range(15)), 24'($urandom()), 24'($urandom()));
      end else if (pick < 28) begin
         send_pose(loaded_x[slot], loaded_y[slot], 16'($urandom()));
      end else if (pick < 88) begin
         if (pick >= 78) slot = 4'($urandom_range(15));
         send_pose(near(loaded_x[slot], spread_now), near(loaded_y[slot], spread_now),
                   16'($urandom()));
      end else begin
         send_pose(24'($urandom()), 24'($urandom()), 16'($urandom()));
      end
   endtask

   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // fill the whole store first so no pose ever reads an empty slot
      send_load(4'd0, POS_MAX, POS_MAX);
      send_load(4'd1, POS_MIN, POS_MIN);
      send_load(4'd2, 24'sd0, 24'sd0);
      send_load(4'd3, POS_MIN, POS_MAX);
      for (int s = 4; s < 16; s++) begin
         send_load(4'(s), 24'($urandom()), 24'($urandom()));
      end

      // longest distance, target on top of boat, straight ahead, due east
      send_pose(POS_MIN, POS_MIN, 16'h8000);
      send_pose(POS_MAX, POS_MAX, 16'h7FFF);
      send_pose(POS_MAX, POS_MIN, 16'h0000);
      send_pose(POS_MIN, POS_MAX, 16'($urandom()));

      // step through the route one waypoint at a time
      set_mode(16, 4096);
      send_pose(loaded_x[0], loaded_y[0], 16'($urandom()));
      send_pose(POS_MIN + 24'sd100, POS_MIN + 24'sd200, 16'($urandom()));
      send_pose(-24'sd300, 24'sd0, 16'($urandom()));
      send_pose(POS_MIN + 24'sd5, POS_MAX - 24'sd7, 16'($urandom()));

      // shrink the route below the current index so the next arrival wraps
      set_mode(2, 4096);
      send_pose(near(loaded_x[4], 64), near(loaded_y[4], 64), 16'($urandom()));
      send_pose(POS_MAX - 24'sd10, POS_MAX, 16'($urandom()));

      for (int p = 0; p < PHASES; p++) begin
         if (p == 3) begin
            send_idle_pct = 71;
            recv_idle_pct = 15;
         end else if (p == 6) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         set_mode(phase_count[p], phase_radius[p]);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (p == 6 && n == 5) holds_asked++;
            random_item();
         end
      end

      wait_idle();
      $display("covered %0d waypoint loads and %0d poses over %0d register settings",
               loads_sent, poses_sent, settings_used);
      $display("%0d responses checked, %0d of them arrivals", checked, advances);
      if (failures == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/wbg_pkg.sv
hw/rtl/wbg_ctrl.sv
hw/rtl/wbg_datapath.sv
hw/rtl/waypoint_bearing_guidance.sv
tb/guidance_checker.sv
tb/testbench.sv
